@@ sv/double_ended_queue_unit_defines.svh @@
// assertion macros used by the double-ended queue rtl
// expects signals named clock and reset in the module that uses them
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is high
`define DQU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dqu assertion failed");

// next-cycle implication, off while reset is high
`define DQU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dqu assertion failed");

`endif

@@ sv/dqu_pkg.sv @@
// shared types and codes for the double-ended queue unit
// used by dqu_cell and double_ended_queue_unit
package dqu_pkg;

   localparam int VALUE_W  = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_ALL   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // what every cell of the chain does this cycle
   typedef struct packed {
      logic shift_up;    // take the lower neighbor (push at front)
      logic shift_down;  // take the upper neighbor (pop at front)
      logic rotate;      // read-out step: tail takes the front entry
      logic append;      // the cell just past the tail loads the value
   } cell_op_type;

endpackage

@@ sv/dqu_cell.sv @@
// one storage cell of the deque chain
// depends on dqu_pkg for cell_op_type and VALUE_W
module dqu_cell
   import dqu_pkg::*;
(
   input  logic               clock,
   input  cell_op_type        op,
   input  logic               at_tail,
   input  logic               at_fill,
   input  logic [VALUE_W-1:0] lower_data,
   input  logic [VALUE_W-1:0] upper_data,
   input  logic [VALUE_W-1:0] front_data,
   input  logic [VALUE_W-1:0] push_data,
   output logic [VALUE_W-1:0] data
);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (op.shift_up) begin
         data_in = lower_data;
      end else if (op.shift_down) begin
         data_in = upper_data;
      end else if (op.rotate) begin
         data_in = at_tail ? front_data : upper_data;
      end else if (op.append && at_fill) begin
         data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ sv/double_ended_queue_unit.sv @@
// Bounded double-ended queue of 32-bit values held in a chain of DEPTH cells, front entry
// in cell 0. Push and pop each give one result item; the whole chain shifts one place
// for front operations. A read-out gives one result item per stored entry, one per cycle
// while the output is not held back, by rotating the occupied part of the chain once
// round through cell 0, and no new item is taken while it runs.
// Results pass through one output register; a new item is taken while the last result is
// being taken. Status 1 reports an empty queue, status 2 a refused push into a full one.
// depends on dqu_pkg, dqu_cell and double_ended_queue_unit_defines.svh
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit
   import dqu_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_value, [36:32] occupancy, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic               out_free;
   logic               accept;
   logic               is_empty;
   logic               is_full;
   logic [CW-1:0]      count_m1;
   logic [CW-1:0]      count_next;
   cell_op_type        op;
   logic [VALUE_W-1:0] cell_data [DEPTH];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CW'(DEPTH));
   assign count_m1   = count_ff - CW'(1);

   always_comb begin
      op         = '0;
      count_next = count_ff;
      unique case (req_tuser) inside
         CMD_PUSH_FRONT: begin
            op.shift_up = accept && !is_full;
            if (!is_full) count_next = count_ff + CW'(1);
         end
         CMD_PUSH_BACK: begin
            op.append = accept && !is_full;
            if (!is_full) count_next = count_ff + CW'(1);
         end
         CMD_POP_FRONT: begin
            op.shift_down = accept && !is_empty;
            if (!is_empty) count_next = count_m1;
         end
         CMD_POP_BACK: begin
            if (!is_empty) count_next = count_m1;
         end
         default: begin
         end
      endcase
      op.rotate = (state_ff == ST_READ) && out_free;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [VALUE_W-1:0] lower_data;
         logic [VALUE_W-1:0] upper_data;
         if (i == 0) begin : g_first
            assign lower_data = req_tdata;
         end else begin : g_mid
            assign lower_data = cell_data[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign upper_data = cell_data[i];
         end else begin : g_upper
            assign upper_data = cell_data[i+1];
         end
         dqu_cell u_cell (
            .clock      (clock),
            .op         (op),
            .at_tail    (count_m1 == CW'(i)),
            .at_fill    (count_ff == CW'(i)),
            .lower_data (lower_data),
            .upper_data (upper_data),
            .front_data (cell_data[0]),
            .push_data  (req_tdata),
            .data       (cell_data[i])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;

      if (accept) begin
         count_in      = count_next;
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_data_in   = '0;
         rsp_last_in   = 1'b1;
         rsp_occ_in    = OCC_W'(count_next);
         unique case (req_tuser) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (is_full) rsp_status_in = STATUS_FULL;
            end
            CMD_POP_FRONT: begin
               if (is_empty) rsp_status_in = STATUS_EMPTY;
               else rsp_data_in = cell_data[0];
            end
            CMD_POP_BACK: begin
               if (is_empty) rsp_status_in = STATUS_EMPTY;
               else rsp_data_in = cell_data[count_m1[IW-1:0]];
            end
            CMD_READ_ALL: begin
               if (is_empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  // results come out of the read-out loop instead
                  rsp_valid_in = 1'b0;
                  remain_in    = count_ff;
                  state_in     = ST_READ;
               end
            end
            default: begin
            end
         endcase
      end else if (op.rotate) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_data_in   = cell_data[0];
         rsp_last_in   = (remain_ff == CW'(1));
         rsp_occ_in    = OCC_W'(count_ff);
         remain_in     = remain_ff - CW'(1);
         if (remain_ff == CW'(1)) state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `DQU_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH))
   `DQU_ASSERT_NOW(a_read_blocks_input, state_ff == ST_READ, !req_tready)
   `DQU_ASSERT_NOW(a_read_has_work, state_ff == ST_READ, remain_ff != '0 && !is_empty)
   `DQU_ASSERT_NEXT(a_count_only_on_accept, !accept, $stable(count_ff))
   `DQU_ASSERT_NEXT(a_read_start, accept && req_tuser == CMD_READ_ALL && !is_empty,
                    state_ff == ST_READ && remain_ff == $past(count_ff))

endmodule
